FILE: rtl/core/bcv_pkg.sv
// Package for the birthday collision verifier.
// Holds SHA-512 constants, verdict codes, controller states and command and status structs.
package bcv_pkg;

    localparam int unsigned BIRTHDAY_BITS_DEF = 50;
    localparam int unsigned BDAY_W            = 50;
    localparam logic [31:0] MAX_NONCE_RESET   = 32'd67108864;
    localparam int unsigned ROUNDS            = 80;

    typedef enum logic [1:0] {
        VERDICT_MATCH  = 2'd0,
        VERDICT_EQUAL  = 2'd1,
        VERDICT_LIMIT  = 2'd2,
        VERDICT_DIFFER = 2'd3
    } verdict_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH_A,
        ST_HASH_B,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic start_a;
        logic start_b;
        logic round;
        logic keep_a;
        logic keep_b;
    } cmd_t;

    typedef struct packed {
        logic early;
        logic last_round;
    } status_t;

    function automatic logic [63:0] round_k(input logic [6:0] i);
        logic [63:0] k;
        begin
            unique case (i)
                7'd0: k = 64'h428a2f98d728ae22;   7'd1: k = 64'h7137449123ef65cd;
                7'd2: k = 64'hb5c0fbcfec4d3b2f;   7'd3: k = 64'he9b5dba58189dbbc;
                7'd4: k = 64'h3956c25bf348b538;   7'd5: k = 64'h59f111f1b605d019;
                7'd6: k = 64'h923f82a4af194f9b;   7'd7: k = 64'hab1c5ed5da6d8118;
                7'd8: k = 64'hd807aa98a3030242;   7'd9: k = 64'h12835b0145706fbe;
                7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
                7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
                7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
                7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
                7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
                7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
                7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
                7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
                7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
                7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
                7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
                7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
                7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
                7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
                7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
                7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
                7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
                7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
                7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
                7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
                7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
                7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
                7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
                7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
                7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
                7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
                7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
                7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
                7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
                7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
                7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
                7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
                7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
                7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
                7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
                default: k = 64'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [63:0] iv(input logic [2:0] i);
        logic [63:0] v;
        begin
            unique case (i)
                3'd0: v = 64'h6a09e667f3bcc908;
                3'd1: v = 64'hbb67ae8584caa73b;
                3'd2: v = 64'h3c6ef372fe94f82b;
                3'd3: v = 64'ha54ff53a5f1d36f1;
                3'd4: v = 64'h510e527fade682d1;
                3'd5: v = 64'h9b05688c2b3e6c1f;
                3'd6: v = 64'h1f83d9abfb41bd6b;
                default: v = 64'h5be0cd19137e2179;
            endcase
            return v;
        end
    endfunction

    function automatic logic [63:0] bswap64(input logic [63:0] x);
        logic [63:0] r;
        begin
            for (int i = 0; i < 8; i++) begin
                r[8*i +: 8] = x[8*(7-i) +: 8];
            end
            return r;
        end
    endfunction

endpackage

FILE: rtl/core/bcv_ctrl.sv
// Controller for the birthday collision verifier.
// Sequences two SHA-512 compressions unless the item is rejected early; uses bcv_pkg.
module bcv_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_fire,
    input  logic             out_fire,
    input  bcv_pkg::status_t status,
    output bcv_pkg::cmd_t    cmd,
    output logic             s_ready,
    output logic             m_valid
);

    bcv_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bcv_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            bcv_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (in_fire) begin
                    cmd.load   = 1'b1;
                    state_next = bcv_pkg::ST_FINISH;
                end
            end
            bcv_pkg::ST_FINISH: begin
                if (status.early) begin
                    state_next = bcv_pkg::ST_OUT;
                end else begin
                    cmd.start_a = 1'b1;
                    state_next  = bcv_pkg::ST_HASH_A;
                end
            end
            bcv_pkg::ST_HASH_A: begin
                cmd.round = 1'b1;
                if (status.last_round) begin
                    cmd.keep_a  = 1'b1;
                    cmd.start_b = 1'b1;
                    state_next  = bcv_pkg::ST_HASH_B;
                end
            end
            bcv_pkg::ST_HASH_B: begin
                cmd.round = 1'b1;
                if (status.last_round) begin
                    cmd.keep_b = 1'b1;
                    state_next = bcv_pkg::ST_OUT;
                end
            end
            bcv_pkg::ST_OUT: begin
                m_valid = 1'b1;
                if (out_fire) begin
                    state_next = bcv_pkg::ST_IDLE;
                end
            end
            default: state_next = bcv_pkg::ST_IDLE;
        endcase
    end

endmodule

FILE: rtl/core/bcv_datapath.sv
// Datapath for the birthday collision verifier: message schedule window,
// one shared SHA-512 round unit, birthday extraction. Uses bcv_pkg.
module bcv_datapath #(
    parameter int unsigned BIRTHDAY_BITS = bcv_pkg::BIRTHDAY_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      cfg_we,
    input  logic [31:0]               cfg_wdata,
    input  logic                      aresetn,
    input  logic [255:0]              head,
    input  logic [31:0]               nonce_a,
    input  logic [31:0]               nonce_b,
    input  bcv_pkg::cmd_t             cmd,
    output bcv_pkg::status_t          status,
    output logic [1:0]                verdict,
    output logic [bcv_pkg::BDAY_W-1:0] birthday_a,
    output logic [bcv_pkg::BDAY_W-1:0] birthday_b
);

    localparam int unsigned SHIFT = 64 - BIRTHDAY_BITS;

    logic [31:0]  max_nonce_reg;
    logic [255:0] head_reg;
    logic [31:0]  na_reg, nb_reg;
    logic [1:0]   verdict_reg, verdict_next;
    logic [bcv_pkg::BDAY_W-1:0] ba_reg, bb_reg;
    logic [63:0]  w_reg [16];
    logic [63:0]  st_reg [8];
    logic [6:0]   rnd_reg;
    logic         cur_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_nonce_reg <= bcv_pkg::MAX_NONCE_RESET;
        end else if (cfg_we) begin
            max_nonce_reg <= cfg_wdata;
        end
    end

    // message block words for a given nonce
    logic [31:0]  nsel;
    logic [7:0]   blk [128];
    logic [63:0]  wi  [16];

    assign nsel = cmd.start_b ? nb_reg : na_reg;

    always_comb begin
        for (int i = 0; i < 128; i++) begin
            blk[i] = 8'h00;
        end
        for (int i = 0; i < 4; i++) begin
            blk[i] = nsel[8*i +: 8] & ((i == 0) ? 8'hF8 : 8'hFF);
        end
        for (int i = 0; i < 32; i++) begin
            blk[4+i] = head_reg[8*i +: 8];
        end
        blk[36]  = 8'h80;
        blk[126] = 8'h01;
        blk[127] = 8'h20;
        for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < 8; j++) begin
                wi[i][8*(7-j) +: 8] = blk[8*i+j];
            end
        end
    end

    logic [63:0] s0, s1, wnew, t1, t2, e, a, wcur;
    assign wcur = w_reg[0];
    assign s0 = {w_reg[1][0], w_reg[1][63:1]} ^ {w_reg[1][7:0], w_reg[1][63:8]}
              ^ (w_reg[1] >> 7);
    assign s1 = {w_reg[14][18:0], w_reg[14][63:19]} ^ {w_reg[14][60:0], w_reg[14][63:61]}
              ^ (w_reg[14] >> 6);
    assign wnew = w_reg[0] + s0 + w_reg[9] + s1;
    assign a = st_reg[0];
    assign e = st_reg[4];
    assign t1 = st_reg[7] + ({e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]})
              + ((e & st_reg[5]) ^ (~e & st_reg[6])) + bcv_pkg::round_k(rnd_reg) + wcur;
    assign t2 = ({a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]})
              + ((a & st_reg[1]) ^ (a & st_reg[2]) ^ (st_reg[1] & st_reg[2]));

    // final digest word and birthday, taken as the last round retires
    logic [63:0] fin [8];
    logic [2:0]  ksel;
    logic [63:0] dword, bword;
    logic [bcv_pkg::BDAY_W-1:0] bday;

    always_comb begin
        fin[0] = t1 + t2;
        fin[1] = st_reg[0];
        fin[2] = st_reg[1];
        fin[3] = st_reg[2];
        fin[4] = st_reg[3] + t1;
        fin[5] = st_reg[4];
        fin[6] = st_reg[5];
        fin[7] = st_reg[6];
        ksel   = cur_b_reg ? nb_reg[2:0] : na_reg[2:0];
        dword  = fin[ksel] + bcv_pkg::iv(ksel);
        bword  = bcv_pkg::bswap64(dword) >> SHIFT;
        bday   = bword[bcv_pkg::BDAY_W-1:0];
    end

    assign status.last_round = (rnd_reg == 7'(bcv_pkg::ROUNDS - 1));
    assign status.early      = (verdict_reg == bcv_pkg::VERDICT_EQUAL)
                            || (verdict_reg == bcv_pkg::VERDICT_LIMIT);

    always_comb begin
        priority if (nonce_a == nonce_b) begin
            verdict_next = bcv_pkg::VERDICT_EQUAL;
        end else if (nonce_a > max_nonce_reg || nonce_b > max_nonce_reg) begin
            verdict_next = bcv_pkg::VERDICT_LIMIT;
        end else begin
            verdict_next = bcv_pkg::VERDICT_MATCH;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            head_reg    <= head;
            na_reg      <= nonce_a;
            nb_reg      <= nonce_b;
            verdict_reg <= verdict_next;
            ba_reg      <= '0;
            bb_reg      <= '0;
        end
        if (cmd.start_a || cmd.start_b) begin
            for (int i = 0; i < 16; i++) begin
                w_reg[i] <= wi[i];
            end
            for (int i = 0; i < 8; i++) begin
                st_reg[i] <= bcv_pkg::iv(3'(i));
            end
            rnd_reg   <= '0;
            cur_b_reg <= cmd.start_b;
        end else if (cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= wnew;
            st_reg[0] <= t1 + t2;
            st_reg[1] <= st_reg[0];
            st_reg[2] <= st_reg[1];
            st_reg[3] <= st_reg[2];
            st_reg[4] <= st_reg[3] + t1;
            st_reg[5] <= st_reg[4];
            st_reg[6] <= st_reg[5];
            st_reg[7] <= st_reg[6];
            rnd_reg   <= rnd_reg + 7'd1;
        end
        if (cmd.keep_a) begin
            ba_reg <= bday;
        end
        if (cmd.keep_b) begin
            bb_reg <= bday;
            verdict_reg <= (ba_reg == bday) ? bcv_pkg::VERDICT_MATCH
                                            : bcv_pkg::VERDICT_DIFFER;
        end
    end

    assign verdict    = verdict_reg;
    assign birthday_a = ba_reg;
    assign birthday_b = bb_reg;

endmodule

FILE: rtl/core/birthday_collision_verify.sv
// Each item has both nonces hashed (two SHA-512 compressions of 80 rounds
// through one shared round unit) unless it is rejected early; a new item is
// taken once the result has been transferred.
// max_nonce resets to 1<<26. Depends on bcv_pkg, bcv_ctrl, bcv_datapath.
module birthday_collision_verify #(
    parameter int unsigned BIRTHDAY_BITS = bcv_pkg::BIRTHDAY_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [319:0] s_tdata,  // head_word0..3, nonce_a, nonce_b
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata   // verdict, birthday_a, birthday_b, zero fill
);

    bcv_pkg::cmd_t    cmd;
    bcv_pkg::status_t status;
    logic [1:0]       verdict;
    logic [bcv_pkg::BDAY_W-1:0] ba, bb;

    bcv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (s_tvalid && s_tready),
        .out_fire (m_tvalid && m_tready),
        .status   (status),
        .cmd      (cmd),
        .s_ready  (s_tready),
        .m_valid  (m_tvalid)
    );

    bcv_datapath #(
        .BIRTHDAY_BITS (BIRTHDAY_BITS)
    ) u_dp (
        .aclk       (aclk),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .aresetn    (aresetn),
        .head       (s_tdata[255:0]),
        .nonce_a    (s_tdata[287:256]),
        .nonce_b    (s_tdata[319:288]),
        .cmd        (cmd),
        .status     (status),
        .verdict    (verdict),
        .birthday_a (ba),
        .birthday_b (bb)
    );

    assign m_tdata = {2'b00, bb, ba, verdict};

endmodule

FILE: rtl/core/bcv_checker.sv
// Port checker for birthday_collision_verify, bound to the top level.
// Depends on bcv_pkg and the top level's ports.
module bcv_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready while result pending");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");

    a_early_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == bcv_pkg::VERDICT_EQUAL
                     || m_tdata[1:0] == bcv_pkg::VERDICT_LIMIT)
        |-> m_tdata[101:2] == '0) else $error("early reject with birthdays");

    a_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == bcv_pkg::VERDICT_MATCH
        |-> m_tdata[51:2] == m_tdata[101:52])
        else $error("match with differing birthdays");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("second accept");

endmodule

bind birthday_collision_verify bcv_checker u_bcv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
